// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL; they vanish when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define QTE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define QTE_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define QTE_ASSERT(lbl, prop)
`define QTE_ASSERT_NEVER(lbl, expr)
`endif
`endif

// File: rtl/qte_pkg.sv
package qte_pkg;

  localparam int unsigned TermW      = 34;
  localparam int unsigned CordicW    = 52;
  localparam int unsigned AccW       = 20;
  localparam int unsigned CordicSteps = 17;
  localparam int unsigned SqrtSteps  = 29;
  localparam int unsigned RadW       = 58;
  localparam int unsigned RootW      = 29;
  localparam int unsigned RemW       = 32;

  localparam logic signed [AccW-1:0] PiQ16     = 20'sd205887;
  localparam logic signed [15:0]     PiQ13     = 16'sd25736;
  localparam logic signed [15:0]     HalfPiQ13 = 16'sd12868;
  localparam logic signed [TermW-1:0] OneQ28   = 34'sd268435456;

  function automatic logic signed [AccW-1:0] atan_tab(input int unsigned i);
    logic signed [AccW-1:0] v;
    case (i)
      0:  v = 20'sd51472;
      1:  v = 20'sd30386;
      2:  v = 20'sd16055;
      3:  v = 20'sd8150;
      4:  v = 20'sd4091;
      5:  v = 20'sd2047;
      6:  v = 20'sd1024;
      7:  v = 20'sd512;
      8:  v = 20'sd256;
      9:  v = 20'sd128;
      10: v = 20'sd64;
      11: v = 20'sd32;
      12: v = 20'sd16;
      13: v = 20'sd8;
      14: v = 20'sd4;
      15: v = 20'sd2;
      16: v = 20'sd1;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/qte_isqrt.sv
module qte_isqrt (
  input  logic                           clk_i,
  input  logic [qte_pkg::RadW-1:0]       rad_i,
  output logic [qte_pkg::RootW-1:0]      root_o
);

  localparam int unsigned N = qte_pkg::SqrtSteps;

  logic [qte_pkg::RemW-1:0]  rem_q  [0:N-1];
  logic [qte_pkg::RootW-1:0] root_q [0:N-1];
  logic [qte_pkg::RadW-1:0]  rest_q [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [qte_pkg::RemW-1:0]  rem_p, rem_d, trial;
    logic [qte_pkg::RootW-1:0] root_p;
    logic [qte_pkg::RadW-1:0]  rest_p;
    logic                      ge;
    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rest_p = rad_i;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign rest_p = rest_q[k-1];
    end
    always_comb begin
      rem_d = {rem_p[qte_pkg::RemW-3:0], rest_p[qte_pkg::RadW-1 -: 2]};
      trial = {1'b0, root_p, 2'b01};
      ge    = (rem_d >= trial);
    end
    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? rem_d - trial : rem_d;
      root_q[k] <= {root_p[qte_pkg::RootW-2:0], ge};
      rest_q[k] <= {rest_p[qte_pkg::RadW-3:0], 2'b00};
    end
  end

  assign root_o = root_q[N-1];

endmodule

// File: rtl/qte_cordic.sv
module qte_cordic (
  input  logic                              clk_i,
  input  logic signed [qte_pkg::TermW-1:0]  y_i,
  input  logic signed [qte_pkg::TermW-1:0]  x_i,
  output logic signed [15:0]                angle_o
);

  localparam int unsigned N = qte_pkg::CordicSteps;
  localparam int unsigned W = qte_pkg::CordicW;
  localparam int unsigned A = qte_pkg::AccW;

  logic signed [W-1:0] x_q   [0:N];
  logic signed [W-1:0] y_q   [0:N];
  logic signed [A-1:0] acc_q [0:N];
  logic                zero_q [0:N];
  logic signed [15:0]  angle_q;

  logic signed [W-1:0] xe, ye;
  assign xe = {{(W-qte_pkg::TermW-16){x_i[qte_pkg::TermW-1]}}, x_i, 16'b0};
  assign ye = {{(W-qte_pkg::TermW-16){y_i[qte_pkg::TermW-1]}}, y_i, 16'b0};

  always_ff @(posedge clk_i) begin
    zero_q[0] <= (x_i == '0) && (y_i == '0);
    if (xe[W-1]) begin
      x_q[0]   <= -xe;
      y_q[0]   <= -ye;
      acc_q[0] <= ye[W-1] ? -qte_pkg::PiQ16 : qte_pkg::PiQ16;
    end else begin
      x_q[0]   <= xe;
      y_q[0]   <= ye;
      acc_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [W-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      zero_q[i+1] <= zero_q[i];
      if (!y_q[i][W-1]) begin
        x_q[i+1]   <= x_q[i] + ys;
        y_q[i+1]   <= y_q[i] - xs;
        acc_q[i+1] <= acc_q[i] + qte_pkg::atan_tab(i);
      end else begin
        x_q[i+1]   <= x_q[i] - ys;
        y_q[i+1]   <= y_q[i] + xs;
        acc_q[i+1] <= acc_q[i] - qte_pkg::atan_tab(i);
      end
    end
  end

  logic signed [A-1:0] rnd;
  logic signed [15:0]  angle_d;
  always_comb begin
    rnd = (acc_q[N] + A'(signed'(4))) >>> 3;
    if (zero_q[N]) begin
      angle_d = '0;
    end else if (rnd > A'(qte_pkg::PiQ13)) begin
      angle_d = qte_pkg::PiQ13;
    end else if (rnd < -A'(qte_pkg::PiQ13)) begin
      angle_d = -qte_pkg::PiQ13;
    end else begin
      angle_d = rnd[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
  end

  assign angle_o = angle_q;

endmodule

// File: rtl/quaternion_to_euler_angles.sv
// Converts a quaternion (w, x, y, z in signed Q1.14) to roll, pitch and yaw
// in radians, signed Q2.13 (pitch Q1.13); a flag marks a clamped pitch.
// A beat enters when start is high at a rising clock edge; busy is always
// low, so a new quaternion can enter in every cycle.
// Each beat comes back shown for one cycle with out_valid_o high; results
// leave in the order the beats entered.
// A beat runs through three product stages, the 29-stage square root
// pipeline for the pitch cosine, the 19-stage CORDIC pipelines that follow
// it and one output register.
// Throughput is one beat per cycle for any input stream.
// The receiver cannot stall, so the pipeline never holds.
// Reset clears all valid bits, so no result is shown after reset until
// a new beat has gone through the pipeline.
module quaternion_to_euler_angles (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               out_valid_o,
  output logic signed [15:0] roll_angle_o,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o,
  output logic               gimbal_clamped_o
);

  `include "assert_macros.svh"

  localparam int unsigned TW  = qte_pkg::TermW;
  localparam int unsigned SN  = qte_pkg::SqrtSteps;
  localparam int unsigned CN  = qte_pkg::CordicSteps + 2;
  localparam int unsigned Lat = 3 + SN + CN + 1;

  typedef struct packed {
    logic signed [TW-1:0] sr;
    logic signed [TW-1:0] cr;
    logic signed [TW-1:0] sy;
    logic signed [TW-1:0] cy;
    logic signed [TW-1:0] sp;
    logic                 gimbal;
  } terms_t;

  typedef struct packed {
    logic gimbal;
    logic sp_neg;
  } side_t;

  assign busy = 1'b0;

  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, zx_q;
  logic               v1_q, v2_q, v3_q;
  terms_t             t2_q, t3_q;
  terms_t             t2_d;
  logic [27:0]        spm_q;
  logic [55:0]        s2_q;

  always_ff @(posedge clk_i) begin
    wx_q <= quat_w_i * quat_x_i;
    yz_q <= quat_y_i * quat_z_i;
    xx_q <= quat_x_i * quat_x_i;
    yy_q <= quat_y_i * quat_y_i;
    wz_q <= quat_w_i * quat_z_i;
    xy_q <= quat_x_i * quat_y_i;
    zz_q <= quat_z_i * quat_z_i;
    wy_q <= quat_w_i * quat_y_i;
    zx_q <= quat_z_i * quat_x_i;
  end

  logic signed [TW-1:0] spa;
  always_comb begin
    t2_d.sr = (TW'(wx_q) + TW'(yz_q)) <<< 1;
    t2_d.cr = qte_pkg::OneQ28 - ((TW'(xx_q) + TW'(yy_q)) <<< 1);
    t2_d.sy = (TW'(wz_q) + TW'(xy_q)) <<< 1;
    t2_d.cy = qte_pkg::OneQ28 - ((TW'(yy_q) + TW'(zz_q)) <<< 1);
    t2_d.sp = (TW'(wy_q) - TW'(zx_q)) <<< 1;
    t2_d.gimbal = (t2_d.sp >= qte_pkg::OneQ28) || (t2_d.sp <= -qte_pkg::OneQ28);
    spa = t2_d.sp[TW-1] ? -t2_d.sp : t2_d.sp;
  end

  always_ff @(posedge clk_i) begin
    t2_q  <= t2_d;
    spm_q <= spa[27:0];
    t3_q  <= t2_q;
    s2_q  <= spm_q * spm_q;
  end

  logic [qte_pkg::RadW-1:0]  rad;
  logic [qte_pkg::RootW-1:0] root;
  assign rad = {2'b01, 56'b0} - {2'b00, s2_q};

  qte_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rad_i  (rad),
    .root_o (root)
  );

  terms_t dly_q [0:SN-1];
  logic   dv_q  [0:SN-1];
  side_t  ctl_q [0:CN-1];
  logic   cv_q  [0:CN-1];

  always_ff @(posedge clk_i) begin
    dly_q[0] <= t3_q;
    for (int k = 1; k < SN; k++) dly_q[k] <= dly_q[k-1];
    ctl_q[0] <= '{gimbal: dly_q[SN-1].gimbal, sp_neg: dly_q[SN-1].sp[TW-1]};
    for (int k = 1; k < CN; k++) ctl_q[k] <= ctl_q[k-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      for (int k = 0; k < SN; k++) dv_q[k] <= 1'b0;
      for (int k = 0; k < CN; k++) cv_q[k] <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      v1_q <= start;
      v2_q <= v1_q;
      v3_q <= v2_q;
      dv_q[0] <= v3_q;
      for (int k = 1; k < SN; k++) dv_q[k] <= dv_q[k-1];
      cv_q[0] <= dv_q[SN-1];
      for (int k = 1; k < CN; k++) cv_q[k] <= cv_q[k-1];
      out_valid_o <= cv_q[CN-1];
    end
  end

  logic signed [15:0] roll, pitch, yaw;

  qte_cordic u_roll (
    .clk_i   (clk_i),
    .y_i     (dly_q[SN-1].sr),
    .x_i     (dly_q[SN-1].cr),
    .angle_o (roll)
  );

  qte_cordic u_yaw (
    .clk_i   (clk_i),
    .y_i     (dly_q[SN-1].sy),
    .x_i     (dly_q[SN-1].cy),
    .angle_o (yaw)
  );

  qte_cordic u_pitch (
    .clk_i   (clk_i),
    .y_i     (dly_q[SN-1].sp),
    .x_i     ({{(TW-qte_pkg::RootW){1'b0}}, root}),
    .angle_o (pitch)
  );

  logic signed [15:0] pitch_d;
  always_comb begin
    if (ctl_q[CN-1].gimbal) begin
      pitch_d = ctl_q[CN-1].sp_neg ? -qte_pkg::HalfPiQ13 : qte_pkg::HalfPiQ13;
    end else if (pitch > qte_pkg::HalfPiQ13) begin
      pitch_d = qte_pkg::HalfPiQ13;
    end else if (pitch < -qte_pkg::HalfPiQ13) begin
      pitch_d = -qte_pkg::HalfPiQ13;
    end else begin
      pitch_d = pitch;
    end
  end

  always_ff @(posedge clk_i) begin
    roll_angle_o     <= roll;
    yaw_angle_o      <= yaw;
    pitch_angle_o    <= pitch_d[14:0];
    gimbal_clamped_o <= ctl_q[CN-1].gimbal & cv_q[CN-1];
  end

  `QTE_ASSERT(a_latency, start |-> ##Lat out_valid_o)
  `QTE_ASSERT(a_gimbal_pitch, out_valid_o && gimbal_clamped_o |->
    (pitch_angle_o == 15'sd12868) || (pitch_angle_o == -15'sd12868))
  `QTE_ASSERT(a_roll_range, out_valid_o |->
    (roll_angle_o <= 16'sd25736) && (roll_angle_o >= -16'sd25736))
  `QTE_ASSERT_NEVER(a_flag_no_beat, gimbal_clamped_o && !out_valid_o)

endmodule
